// ===== rtl/core/ewb_pkg.sv =====
// shared types and constants of the equal-width binning block
`default_nettype none

package ewb_pkg;

    localparam int DATA_W = 32;
    localparam int LVL_W  = 6;
    localparam int TOL_W  = 16;
    localparam int IDX_W  = 10;
    // dividend holds d*n + range-1 at most, one bit above the product
    localparam int DIV_W  = DATA_W + LVL_W + 1;

    localparam logic signed [DATA_W-1:0] MIN_RESET = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] MAX_RESET = 32'sh8000_0000;

    typedef enum logic [1:0] {
        REQ_LOAD     = 2'd0,
        REQ_FINISH   = 2'd1,
        REQ_CLASSIFY = 2'd2,
        REQ_CLEAR    = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_LEN = 2'd1,
        ST_BAD      = 2'd2
    } t_status;

    typedef enum logic {
        CFG_NUM_LEVELS = 1'b0,
        CFG_TOLERANCE  = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_PLAN,
        BS_MUL,
        BS_DIV,
        BS_EMIT
    } t_bstate;

    // word handed from the front to the back, with a snapshot of min and max
    typedef struct packed {
        logic                     is_cls;
        logic                     err;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] run_min;
        logic signed [DATA_W-1:0] run_max;
    } t_cmd;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [LVL_W-1:0]         level;
        t_status                  status;
        logic                     last;
    } t_res;

    // request to the shared divider
    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DATA_W-1:0] divisor;
    } t_div_req;

endpackage

`default_nettype wire

// ===== rtl/core/ewb_fifo.sv =====
// small first-in first-out queue of words
`default_nettype none

module ewb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_rdata,
    output logic                  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr;
    logic [PW-1:0]    r_rptr;
    logic [CW-1:0]    r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ewb_front.sv =====
// front end: takes requests, keeps the sample store, count, minimum and maximum
`default_nettype none

module ewb_front #(
    parameter int MAX_SAMPLES = 1024
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire logic [1:0]                 i_req_type,
    input  wire logic signed [31:0]         i_sample,
    input  wire logic [ewb_pkg::IDX_W-1:0]  i_sample_index,
    output logic                            o_full,
    output logic                            o_cmd_push,
    output ewb_pkg::t_cmd                   o_cmd,
    input  wire logic                       i_cmd_full
);

    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int IW = ewb_pkg::IDX_W;
    localparam int XW = (CW > IW) ? CW : IW;

    logic [31:0]        r_store [MAX_SAMPLES];
    logic [CW-1:0]      r_count;
    logic signed [31:0] r_min;
    logic signed [31:0] r_max;
    logic               r_pend;
    logic               r_is_cls;
    logic               r_err;
    logic signed [31:0] r_snap_min;
    logic signed [31:0] r_snap_max;
    logic signed [31:0] r_rd;

    ewb_pkg::t_req      req;
    logic               accept;
    logic               has_room;
    logic               is_query;
    logic [XW-1:0]      idx_x;
    logic [XW-1:0]      cnt_x;

    assign req      = ewb_pkg::t_req'(i_req_type);
    assign o_full   = r_pend || i_cmd_full;
    assign accept   = i_push && !o_full;
    assign has_room = (r_count < CW'(MAX_SAMPLES));
    assign is_query = (req == ewb_pkg::REQ_FINISH) || (req == ewb_pkg::REQ_CLASSIFY);
    assign idx_x    = XW'(i_sample_index);
    assign cnt_x    = XW'(r_count);

    // command word leaves with the registered store read and snapshot once the command queue has room
    assign o_cmd_push     = r_pend && !i_cmd_full;
    assign o_cmd.is_cls   = r_is_cls;
    assign o_cmd.err      = r_err;
    assign o_cmd.value    = r_rd;
    assign o_cmd.run_min  = r_snap_min;
    assign o_cmd.run_max  = r_snap_max;

    // count, running extremes and the pending flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_min   <= ewb_pkg::MIN_RESET;
            r_max   <= ewb_pkg::MAX_RESET;
            r_pend  <= 1'b0;
        end else begin
            if (o_cmd_push) begin
                r_pend <= 1'b0;
            end
            if (accept) begin
                case (req)
                    ewb_pkg::REQ_LOAD: begin
                        if (has_room) begin
                            r_count <= r_count + CW'(1);
                            if (i_sample < r_min) begin
                                r_min <= i_sample;
                            end
                            if (i_sample > r_max) begin
                                r_max <= i_sample;
                            end
                        end
                    end
                    ewb_pkg::REQ_CLEAR: begin
                        r_count <= '0;
                        r_min   <= ewb_pkg::MIN_RESET;
                        r_max   <= ewb_pkg::MAX_RESET;
                    end
                    ewb_pkg::REQ_FINISH, ewb_pkg::REQ_CLASSIFY: begin
                        r_pend <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // store write on load, registered read on classify
    always_ff @(posedge i_clk) begin
        if (accept && (req == ewb_pkg::REQ_LOAD) && has_room) begin
            r_store[r_count[AW-1:0]] <= i_sample;
        end
        if (accept && (req == ewb_pkg::REQ_CLASSIFY)) begin
            r_rd <= r_store[idx_x[AW-1:0]];
        end
    end

    // snapshot of the state the query sees
    always_ff @(posedge i_clk) begin
        if (accept && is_query) begin
            r_is_cls   <= (req == ewb_pkg::REQ_CLASSIFY);
            r_err      <= (req == ewb_pkg::REQ_CLASSIFY) ? (idx_x >= cnt_x)
                                                         : (r_count == '0);
            r_snap_min <= r_min;
            r_snap_max <= r_max;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ewb_div.sv =====
// restoring divider, one quotient bit per cycle
`default_nettype none

module ewb_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire ewb_pkg::t_div_req         i_req,
    output logic                           o_done,
    output logic [ewb_pkg::DIV_W-1:0]      o_quotient
);

    localparam int DW = ewb_pkg::DIV_W;
    localparam int VW = ewb_pkg::DATA_W;
    localparam int KW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [KW-1:0] r_cnt;
    logic [DW-1:0] r_q;
    logic [VW:0]   r_rem;
    logic [VW-1:0] r_dvs;

    logic [VW:0]   rem_sh;
    logic          ge;

    // trial subtract of the shifted partial remainder
    assign rem_sh     = {r_rem[VW-1:0], r_q[DW-1]};
    assign ge         = (rem_sh >= {1'b0, r_dvs});
    assign o_done     = r_done;
    assign o_quotient = r_q;

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= KW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - KW'(1);
                if (r_cnt == KW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out as quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DW-2:0], ge};
            r_rem <= ge ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ewb_back.sv =====
// back end: sequences cutpoints and level codes through the shared divider
`default_nettype none

module ewb_back #(
    parameter int MAX_LEVELS = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cmd_valid,
    input  wire ewb_pkg::t_cmd              i_cmd,
    output logic                            o_cmd_pop,
    input  wire logic [ewb_pkg::LVL_W-1:0]  i_num_levels,
    input  wire logic [ewb_pkg::TOL_W-1:0]  i_tolerance,
    output logic                            o_res_push,
    output ewb_pkg::t_res                   o_res,
    input  wire logic                       i_res_full,
    output ewb_pkg::t_div_req               o_div,
    input  wire logic                       i_div_done,
    input  wire logic [ewb_pkg::DIV_W-1:0]  i_quotient
);

    localparam int LW = ewb_pkg::LVL_W;
    localparam int VW = ewb_pkg::DATA_W;
    localparam int DW = ewb_pkg::DIV_W;
    localparam int PW = VW + LW;

    ewb_pkg::t_bstate   r_state;
    ewb_pkg::t_bstate   n_state;
    ewb_pkg::t_cmd      r_cmd;
    logic [LW-1:0]      r_n;
    logic [LW-1:0]      r_k;
    logic [VW-1:0]      r_range;
    logic [VW-1:0]      r_diff;
    logic [VW-1:0]      r_prev;
    ewb_pkg::t_status   r_status;
    ewb_pkg::t_res      r_res;

    logic [LW-1:0]      eff_n;
    logic [VW-1:0]      mul_a;
    logic [LW-1:0]      mul_b;
    logic [PW-1:0]      prod;
    logic [VW-1:0]      addend;
    logic [VW-1:0]      cut;
    logic [VW-1:0]      gap;
    logic               close;
    logic               shortcut;
    logic               more_cuts;
    logic               div_start;

    // level count clamped into its legal range
    always_comb begin
        if (i_num_levels == '0) begin
            eff_n = LW'(1);
        end else if (i_num_levels > LW'(MAX_LEVELS)) begin
            eff_n = LW'(MAX_LEVELS);
        end else begin
            eff_n = i_num_levels;
        end
    end

    // numerator: k*range for a cutpoint, d*n + range-1 for a level code
    assign mul_a  = r_cmd.is_cls ? r_diff : r_range;
    assign mul_b  = r_cmd.is_cls ? r_n : r_k;
    assign prod   = PW'(mul_a) * PW'(mul_b);
    assign addend = r_cmd.is_cls ? (r_range - VW'(1)) : '0;

    assign o_div.start    = div_start;
    assign o_div.dividend = DW'(prod) + DW'(addend);
    assign o_div.divisor  = r_cmd.is_cls ? r_range : VW'(r_n);

    // cutpoint and spacing check against the previous one
    assign cut       = VW'(r_cmd.run_min) + i_quotient[VW-1:0];
    assign gap       = cut - r_prev;
    assign close     = (r_k != '0) && (gap < VW'(i_tolerance));
    assign shortcut  = r_cmd.err || (r_cmd.is_cls && ((r_cmd.value == r_cmd.run_min) ||
                                                      (r_cmd.run_max == r_cmd.run_min)));
    assign more_cuts = (r_k < r_n);
    assign o_res     = r_res;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ewb_pkg::BS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and strobes
    always_comb begin
        n_state    = r_state;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        div_start  = 1'b0;
        case (r_state)
            ewb_pkg::BS_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_state   = ewb_pkg::BS_PLAN;
                end
            end
            ewb_pkg::BS_PLAN: begin
                n_state = shortcut ? ewb_pkg::BS_EMIT : ewb_pkg::BS_MUL;
            end
            ewb_pkg::BS_MUL: begin
                div_start = 1'b1;
                n_state   = ewb_pkg::BS_DIV;
            end
            ewb_pkg::BS_DIV: begin
                if (i_div_done) begin
                    n_state = ewb_pkg::BS_EMIT;
                end
            end
            ewb_pkg::BS_EMIT: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    if (r_res.last) begin
                        n_state = ewb_pkg::BS_IDLE;
                    end else if (more_cuts) begin
                        n_state = ewb_pkg::BS_MUL;
                    end
                end
            end
            default: begin
                n_state = ewb_pkg::BS_IDLE;
            end
        endcase
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ewb_pkg::BS_IDLE: begin
                if (i_cmd_valid) begin
                    r_cmd    <= i_cmd;
                    r_n      <= eff_n;
                    r_k      <= '0;
                    r_status <= ewb_pkg::ST_OK;
                end
            end
            ewb_pkg::BS_PLAN: begin
                r_range <= VW'(r_cmd.run_max - r_cmd.run_min);
                r_diff  <= VW'(r_cmd.value - r_cmd.run_min);
                if (r_cmd.err) begin
                    r_res <= '{value: '0, level: '0, status: ewb_pkg::ST_BAD, last: 1'b1};
                end else begin
                    r_res <= '{value: r_cmd.value, level: LW'(1),
                               status: ewb_pkg::ST_OK, last: 1'b1};
                end
            end
            ewb_pkg::BS_DIV: begin
                if (i_div_done) begin
                    if (r_cmd.is_cls) begin
                        r_res <= '{value: r_cmd.value, level: i_quotient[LW-1:0],
                                   status: ewb_pkg::ST_OK, last: 1'b1};
                    end else begin
                        r_res  <= '{value: cut, level: r_k,
                                    status: ewb_pkg::ST_OK, last: 1'b0};
                        r_prev <= cut;
                        r_k    <= r_k + LW'(1);
                        if (close) begin
                            r_status <= ewb_pkg::ST_ZERO_LEN;
                        end
                    end
                end
            end
            ewb_pkg::BS_EMIT: begin
                // after the last inner cutpoint the maximum closes the run
                if (!i_res_full && !r_res.last && !more_cuts) begin
                    r_res <= '{value: r_cmd.run_max, level: r_n,
                               status: r_status, last: 1'b1};
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/equal_width_binning.sv =====
// top level of the equal-width binning block
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------------
//  request  | i_push / o_full        | i_req_type, i_sample, i_sample_index
//  result   | o_empty / i_pop        | o_value, o_level, o_status, o_last
//  config   | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  load and clear are taken without holding the input; a classify or finish word holds the
//  input while the store read and snapshot enter the command queue.
//  each cutpoint and each level code takes one pass through the 39-step shared divider;
//  the back end takes no new command until the last result word of the current one is pushed.
//  synchronous active-low reset; the sample store has no reset and no clearing pass.
//  o_full rises while a query word is pending or the command queue is full;
//  results wait in a two-deep output queue, so the back end stalls only when it fills.
`default_nettype none

module equal_width_binning #(
    parameter int MAX_SAMPLES = 1024,
    parameter int MAX_LEVELS  = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    output logic                            o_full,
    input  wire logic [1:0]                 i_req_type,
    input  wire logic signed [31:0]         i_sample,
    input  wire logic [9:0]                 i_sample_index,
    output logic                            o_empty,
    input  wire logic                       i_pop,
    output logic signed [31:0]              o_value,
    output logic [5:0]                      o_level,
    output logic [1:0]                      o_status,
    output logic                            o_last,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic                       i_cfg_index,
    input  wire logic [15:0]                i_cfg_data
);

    localparam int CMD_W = $bits(ewb_pkg::t_cmd);
    localparam int RES_W = $bits(ewb_pkg::t_res);
    localparam int LW    = ewb_pkg::LVL_W;
    localparam int TW    = ewb_pkg::TOL_W;

    logic [LW-1:0]     r_num_levels;
    logic [TW-1:0]     r_tolerance;

    ewb_pkg::t_cmd     cmd_in;
    ewb_pkg::t_cmd     cmd_out;
    logic              cmd_push;
    logic              cmd_full;
    logic              cmd_pop;
    logic              cmd_empty;
    ewb_pkg::t_res     res_in;
    ewb_pkg::t_res     res_out;
    logic              res_push;
    logic              res_full;
    ewb_pkg::t_div_req div_req;
    logic              div_done;
    logic [ewb_pkg::DIV_W-1:0] div_q;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_levels <= LW'(4);
            r_tolerance  <= TW'(1);
        end else if (i_cfg_valid) begin
            case (ewb_pkg::t_cfg_reg'(i_cfg_index))
                ewb_pkg::CFG_NUM_LEVELS: r_num_levels <= i_cfg_data[LW-1:0];
                ewb_pkg::CFG_TOLERANCE:  r_tolerance  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // request side
    ewb_front #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .i_req_type     (i_req_type),
        .i_sample       (i_sample),
        .i_sample_index (i_sample_index),
        .o_full         (o_full),
        .o_cmd_push     (cmd_push),
        .o_cmd          (cmd_in),
        .i_cmd_full     (cmd_full)
    );

    // command queue between front and back
    ewb_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (2)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_wdata (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_rdata (cmd_out),
        .o_empty (cmd_empty)
    );

    // result sequencer
    ewb_back #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (!cmd_empty),
        .i_cmd        (cmd_out),
        .o_cmd_pop    (cmd_pop),
        .i_num_levels (r_num_levels),
        .i_tolerance  (r_tolerance),
        .o_res_push   (res_push),
        .o_res        (res_in),
        .i_res_full   (res_full),
        .o_div        (div_req),
        .i_div_done   (div_done),
        .i_quotient   (div_q)
    );

    // shared divider
    ewb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // result queue
    ewb_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata (res_in),
        .o_full  (res_full),
        .i_pop   (i_pop),
        .o_rdata (res_out),
        .o_empty (o_empty)
    );

    assign o_value  = res_out.value;
    assign o_level  = res_out.level;
    assign o_status = res_out.status;
    assign o_last   = res_out.last;

endmodule

`default_nettype wire

// ===== rtl/core/ewb_checker.sv =====
// port-level checks of the equal-width binning block, bound to the top level
`default_nettype none

module ewb_checker #(
    parameter int MAX_LEVELS = 32
) (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_pop,
    input wire logic               o_empty,
    input wire logic signed [31:0] o_value,
    input wire logic [5:0]         o_level,
    input wire logic [1:0]         o_status,
    input wire logic               o_last
);

    // result queue comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> o_empty)
        else $error("result queue not empty after reset");

    // an error word is a lone, zeroed final word
    a_bad_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && (o_status == ewb_pkg::ST_BAD)) |->
            (o_last && (o_level == '0) && (o_value == '0)))
        else $error("error word is not a zeroed final word");

    // zero-length flag only on the closing cutpoint
    a_zero_len_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && (o_status == ewb_pkg::ST_ZERO_LEN)) |-> o_last)
        else $error("zero-length flag on a word that is not final");

    // level never beyond the level limit
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_level <= 6'(MAX_LEVELS)))
        else $error("level above the level limit");

    // a waiting word keeps its value and last flag until popped
    a_head_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_value) && $stable(o_last)))
        else $error("waiting result word changed");

endmodule

bind equal_width_binning ewb_checker #(
    .MAX_LEVELS (MAX_LEVELS)
) u_ewb_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_pop    (i_pop),
    .o_empty  (o_empty),
    .o_value  (o_value),
    .o_level  (o_level),
    .o_status (o_status),
    .o_last   (o_last)
);

`default_nettype wire
